// ----- rtl/core/pfe_pkg.sv -----
// Playfair digraph encoder: shared types, letter constants and register indexes.
// No dependencies.
package pfe_pkg;

	localparam int unsigned SIDE       = 5;
	localparam int unsigned CELL_COUNT = SIDE * SIDE;
	localparam int unsigned LETTER_W   = 5;
	localparam int unsigned CELLS_A_W  = 50;
	localparam int unsigned CELLS_C_W  = 25;
	localparam int unsigned CFG_DATA_W = 50;
	localparam int unsigned CFG_IDX_W  = 2;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef letter_t [CELL_COUNT-1:0] square_t;
	typedef logic [2:0] coord_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} pos_t;

	localparam letter_t LETTER_I = letter_t'(8);
	localparam letter_t LETTER_J = letter_t'(9);
	localparam letter_t LETTER_X = letter_t'(23);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELLS_FIRST  = 2'd0,
		REG_CELLS_SECOND = 2'd1,
		REG_CELLS_THIRD  = 2'd2
	} reg_idx_t;

	// step one place right or down, wrapping at the square edge
	function automatic coord_t wrap_inc(input coord_t v);
		coord_t r;
		r = (v == coord_t'(SIDE - 1)) ? coord_t'(0) : coord_t'(v + coord_t'(1));
		return r;
	endfunction

	function automatic letter_t cell_at(input square_t sq, input pos_t p);
		logic [4:0] k;
		k = {p.row[2:0], 2'b00} + {2'b00, p.row} + {2'b00, p.col};
		return sq[k];
	endfunction

endpackage

// ----- rtl/core/pfe_ifs.sv -----
// Playfair digraph encoder: valid/ready channel interfaces for letters and ciphers.
// Depends on pfe_pkg.
interface pfe_letter_if import pfe_pkg::*; ();
	logic    valid;
	logic    ready;
	letter_t letter;
	logic    message_end;

	modport source (output valid, letter, message_end, input ready);
	modport sink   (input valid, letter, message_end, output ready);
endinterface

interface pfe_cipher_if import pfe_pkg::*; ();
	logic    valid;
	logic    ready;
	letter_t cipher_letter;
	logic    pair_last;
	logic    message_last;

	modport source (output valid, cipher_letter, pair_last, message_last, input ready);
	modport sink   (input valid, cipher_letter, pair_last, message_last, output ready);
endinterface

// ----- rtl/core/pfe_locate.sv -----
// Playfair digraph encoder: finds the first cell of the key square holding a letter.
// Depends on pfe_pkg. I and J match each other; no match gives row 0, column 0.
module pfe_locate import pfe_pkg::*; (
	input  square_t square,
	input  letter_t letter,
	output pos_t    pos
);

	logic [CELL_COUNT-1:0] hit;

	always_comb begin
		for (int k = 0; k < CELL_COUNT; k++) begin
			hit[k] = (square[k] == letter) ||
			         (letter == LETTER_I && square[k] == LETTER_J) ||
			         (letter == LETTER_J && square[k] == LETTER_I);
		end
	end

	// scan from the last cell back so the lowest matching cell wins
	always_comb begin
		pos = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (hit[r * SIDE + c]) begin
					pos.row = coord_t'(r);
					pos.col = coord_t'(c);
				end
			end
		end
	end

endmodule

// ----- rtl/core/playfair_digraph_encoder_core.sv -----
// Playfair digraph encoder top level: pairing, two-stage lookup, output pair buffer.
// Depends on pfe_pkg, pfe_ifs and pfe_locate.
//
// Usage:
//   letters carries one plaintext letter per word; message_end marks the last one.
//   ciphers returns two words per pair: first with pair_last=0, second with
//   pair_last=1 and message_last set when the pair closes the message.
//   The key square is written through cfg_wr_en/cfg_index/cfg_data while idle.
// Flow:
//   A letter is taken every cycle unless back-pressure drops letters ready. The
//   word that completes a pair is registered at acceptance, the locate stage then
//   registers both positions, and the cipher pair register is loaded from them;
//   the first cipher word is valid from that register, the second once the first
//   is taken. Each pair holds the output port for both its words, which limits
//   the sustained rate when pairs arrive faster than the port drains them.
// Reset clears the square, the held letter and all valid flags.
// A stalled receiver holds the pair register; the two stages behind it keep
// filling, then letters ready drops until the pair drains.
module playfair_digraph_encoder_core import pfe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pfe_letter_if.sink            letters,
	pfe_cipher_if.source          ciphers
);

	logic [CELLS_A_W-1:0] cells_first_q;
	logic [CELLS_A_W-1:0] cells_second_q;
	logic [CELLS_C_W-1:0] cells_third_q;
	square_t              square;

	letter_t held_q;
	logic    holding_q;

	logic    valid_s1;
	letter_t first_s1, second_s1;
	logic    end_s1;

	logic    valid_s2;
	pos_t    pos_a_s2, pos_b_s2;
	logic    end_s2;

	logic    pair_valid_q, phase_q, end_q;
	letter_t ca_q, cb_q;

	pos_t    pos_a, pos_b;
	pos_t    tgt_a, tgt_b;
	logic    pair_free, ready_s2, ready_s1, take;
	logic    closes_pair;
	letter_t first_n, second_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_first_q  <= '0;
			cells_second_q <= '0;
			cells_third_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CELLS_FIRST:  cells_first_q  <= cfg_data;
				REG_CELLS_SECOND: cells_second_q <= cfg_data;
				REG_CELLS_THIRD:  cells_third_q  <= cfg_data[CELLS_C_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 10; k++) begin
			square[k]      = cells_first_q[k*LETTER_W +: LETTER_W];
			square[k + 10] = cells_second_q[k*LETTER_W +: LETTER_W];
		end
		for (int k = 0; k < 5; k++) begin
			square[k + 20] = cells_third_q[k*LETTER_W +: LETTER_W];
		end
	end

	// flow control, from the output back
	assign pair_free     = !pair_valid_q || (ciphers.ready && phase_q);
	assign ready_s2      = !valid_s2 || pair_free;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign letters.ready = ready_s1;
	assign take          = letters.valid && ready_s1;

	// pairing
	always_comb begin
		closes_pair = holding_q || letters.message_end;
		first_n     = holding_q ? held_q : letters.letter;
		second_n    = holding_q ? letters.letter : LETTER_X;
		if (first_n == second_n) begin
			second_n = LETTER_X;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			held_q    <= '0;
		end else if (take) begin
			if (!closes_pair) begin
				held_q    <= letters.letter;
				holding_q <= 1'b1;
			end else begin
				holding_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= take && closes_pair;
		end
	end

	always_ff @(posedge clk) begin
		if (take && closes_pair) begin
			first_s1  <= first_n;
			second_s1 <= second_n;
			end_s1    <= letters.message_end;
		end
	end

	pfe_locate u_locate_a (.square(square), .letter(first_s1),  .pos(pos_a));
	pfe_locate u_locate_b (.square(square), .letter(second_s1), .pos(pos_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			pos_a_s2 <= pos_a;
			pos_b_s2 <= pos_b;
			end_s2   <= end_s1;
		end
	end

	// digraph rules: same row (or same cell) shifts right, same column down,
	// otherwise swap columns
	always_comb begin
		tgt_a = pos_a_s2;
		tgt_b = pos_b_s2;
		if (pos_a_s2.row == pos_b_s2.row) begin
			tgt_a.col = wrap_inc(pos_a_s2.col);
			tgt_b.col = wrap_inc(pos_b_s2.col);
		end else if (pos_a_s2.col == pos_b_s2.col) begin
			tgt_a.row = wrap_inc(pos_a_s2.row);
			tgt_b.row = wrap_inc(pos_b_s2.row);
		end else begin
			tgt_a.col = pos_b_s2.col;
			tgt_b.col = pos_a_s2.col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_q <= 1'b0;
			phase_q      <= 1'b0;
		end else if (pair_free) begin
			pair_valid_q <= valid_s2;
			phase_q      <= 1'b0;
		end else if (ciphers.ready) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_free && valid_s2) begin
			ca_q  <= cell_at(square, tgt_a);
			cb_q  <= cell_at(square, tgt_b);
			end_q <= end_s2;
		end
	end

	assign ciphers.valid         = pair_valid_q;
	assign ciphers.cipher_letter = phase_q ? cb_q : ca_q;
	assign ciphers.pair_last     = phase_q;
	assign ciphers.message_last  = phase_q && end_q;

endmodule

// ----- rtl/core/pfe_checker.sv -----
// Playfair digraph encoder: port-level checker and its bind to the top level.
// Depends on pfe_pkg.
module pfe_checker import pfe_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    out_valid,
	input logic    out_ready,
	input letter_t out_letter,
	input logic    out_pair_last,
	input logic    out_message_last
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable(out_letter) && $stable(out_pair_last) && $stable(out_message_last))
		else $error("cipher word changed while stalled");

	a_msg_on_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_message_last |-> out_pair_last)
		else $error("message_last on first word of a pair");

	// second word of a pair is valid right behind the first once the first is taken
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_pair_last |=> out_valid && out_pair_last)
		else $error("second cipher word missing after first");

	a_first_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_pair_last |=> !(out_valid && out_pair_last))
		else $error("second cipher word repeated");

endmodule

bind playfair_digraph_encoder_core pfe_checker u_pfe_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (ciphers.valid),
	.out_ready        (ciphers.ready),
	.out_letter       (ciphers.cipher_letter),
	.out_pair_last    (ciphers.pair_last),
	.out_message_last (ciphers.message_last)
);

// ----- tb/playfair_digraph_encoder_core_tb.sv -----
// Testbench for playfair_digraph_encoder_core: directed and random letter streams are
// checked word by word against an in-bench Playfair predictor with random idles on both sides.
// Depends on pfe_pkg, pfe_ifs and the core RTL.
module playfair_digraph_encoder_core_tb;
	import pfe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		letter_t cipher_letter;
		logic    pair_last;
		logic    message_last;
	} cipher_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pfe_letter_if letter_bus ();
	pfe_cipher_if cipher_bus ();

	playfair_digraph_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.letters   (letter_bus),
		.ciphers   (cipher_bus)
	);

	// predictor state
	square_t      key_square;
	letter_t      plain_held;
	bit           plain_holding;
	cipher_word_t pending_ciphers[$];

	int fail_count;
	int letters_sent;
	bit steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

	// mostly short gaps, a few long ones; none while steady is set
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// first cell holding the letter, I and J merged; cell 0 when absent
	function automatic int cell_of(letter_t c);
		for (int k = 0; k < CELL_COUNT; k++) begin
			if (key_square[k] == c ||
			    (c == LETTER_I && key_square[k] == LETTER_J) ||
			    (c == LETTER_J && key_square[k] == LETTER_I))
				return k;
		end
		return 0;
	endfunction

	task automatic encipher_letter(letter_t l, bit last);
		letter_t a, b, ea, eb;
		int pa, pb, ra, ca, rb, cb;
		cipher_word_t w;
		if (!plain_holding && !last) begin
			plain_held = l;
			plain_holding = 1'b1;
			return;
		end
		if (plain_holding) begin
			a = plain_held;
			b = l;
			plain_holding = 1'b0;
		end else begin
			a = l;
			b = LETTER_X;
		end
		if (a == b)
			b = LETTER_X;
		pa = cell_of(a);
		pb = cell_of(b);
		ra = pa / SIDE;
		ca = pa % SIDE;
		rb = pb / SIDE;
		cb = pb % SIDE;
		if (ra == rb) begin
			ea = key_square[ra * SIDE + (ca + 1) % SIDE];
			eb = key_square[rb * SIDE + (cb + 1) % SIDE];
		end else if (ca == cb) begin
			ea = key_square[((ra + 1) % SIDE) * SIDE + ca];
			eb = key_square[((rb + 1) % SIDE) * SIDE + cb];
		end else begin
			ea = key_square[ra * SIDE + cb];
			eb = key_square[rb * SIDE + ca];
		end
		w.cipher_letter = ea;
		w.pair_last     = 1'b0;
		w.message_last  = 1'b0;
		pending_ciphers.insert(pending_ciphers.size(), w);
		w.cipher_letter = eb;
		w.pair_last     = 1'b1;
		w.message_last  = last;
		pending_ciphers.insert(pending_ciphers.size(), w);
	endtask

	task automatic send_letter(letter_t l, bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			letter_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		letter_bus.valid       <= 1'b1;
		letter_bus.letter      <= l;
		letter_bus.message_end <= last;
		do @(posedge clk); while (!letter_bus.ready);
		encipher_letter(l, last);
		letters_sent++;
	endtask

	// called at a clock edge while the block is idle
	task automatic load_key_square(square_t sq);
		logic [CELL_COUNT*LETTER_W-1:0] flat;
		flat = sq;
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_CELLS_FIRST;
		cfg_data  <= flat[49:0];
		@(posedge clk);
		cfg_index <= REG_CELLS_SECOND;
		cfg_data  <= flat[99:50];
		@(posedge clk);
		cfg_index <= REG_CELLS_THIRD;
		cfg_data  <= CFG_DATA_W'(flat[124:100]);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		key_square = sq;
	endtask

	// drain all pending cipher words, then give the pipe time to settle
	task automatic wait_idle();
		int n;
		n = 0;
		letter_bus.valid <= 1'b0;
		while (pending_ciphers.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (pending_ciphers.size() != 0) begin
			$error("%0d cipher words never arrived", pending_ciphers.size());
			fail_count++;
			pending_ciphers.delete();
		end
		repeat (10) @(posedge clk);
	endtask

	function automatic square_t random_square();
		letter_t pool[26];
		letter_t t;
		square_t sq;
		int mode, j;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 26; i++)
			pool[i] = letter_t'(i);
		for (int i = 25; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		for (int k = 0; k < CELL_COUNT; k++) begin
			if (mode < 6)
				sq[k] = pool[k];
			else if (mode < 8)
				sq[k] = letter_t'($urandom_range(0, 31));
			else
				sq[k] = pool[$urandom_range(0, 3)];
		end
		return sq;
	endfunction

	function automatic letter_t pick_letter();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return key_square[$urandom_range(0, CELL_COUNT - 1)];
		if (r < 75)
			return $urandom_range(0, 1) ? LETTER_I : LETTER_J;
		if (r < 90)
			return letter_t'($urandom_range(0, 25));
		return letter_t'($urandom_range(0, 31));
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// receiver stalls
	initial begin
		int stall_left;
		stall_left = 0;
		cipher_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				cipher_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				cipher_bus.ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// cipher word checker
	initial begin
		cipher_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && cipher_bus.valid && cipher_bus.ready) begin
				if (pending_ciphers.size() == 0) begin
					$error("unexpected cipher word: cipher_letter %0d",
					       cipher_bus.cipher_letter);
					fail_count++;
				end else begin
					want = pending_ciphers.pop_front();
					check_field("cipher_letter", want.cipher_letter, cipher_bus.cipher_letter);
					check_field("pair_last", want.pair_last, cipher_bus.pair_last);
					check_field("message_last", want.message_last, cipher_bus.message_last);
				end
			end
		end
	end

	// reset square is all A: every unknown letter lands on cell 0
	task automatic test_blank_square();
		send_letter(letter_t'(0), 1'b0);
		send_letter(letter_t'(31), 1'b0);
		send_letter(letter_t'(16), 1'b1);
		send_letter(letter_t'(5), 1'b1);
		wait_idle();
		load_key_square('0);
		send_letter(letter_t'(3), 1'b0);
		send_letter(letter_t'(0), 1'b1);
		wait_idle();
	endtask

	// classic square without J
	task automatic test_directed_pairs();
		square_t sq;
		int n;
		letter_t plain[22] = '{0, 1, 4, 0, 0, 21, 7, 19, 11, 11, 8, 9, 9, 10,
		                       25, 31, 26, 12, 16, 23, 23, 23};
		bit      ends[22]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		                       1, 0, 0, 0, 1, 0, 1, 1};
		n = 0;
		for (int c = 0; c < 26; c++) begin
			if (letter_t'(c) != LETTER_J) begin
				sq[n] = letter_t'(c);
				n++;
			end
		end
		load_key_square(sq);
		// same row, row wrap, column wrap, rectangle, doubled letter, I then J,
		// J lookup, lone final letter, codes outside the square, final while held
		for (int i = 0; i < 22; i++)
			send_letter(plain[i], ends[i]);
		wait_idle();
	endtask

	task automatic test_saturated_square();
		load_key_square('1);
		send_letter(letter_t'(31), 1'b0);
		send_letter(letter_t'(31), 1'b1);
		send_letter(letter_t'(0), 1'b1);
		send_letter(letter_t'(15), 1'b0);
		send_letter(letter_t'(14), 1'b1);
		wait_idle();
	endtask

	task automatic test_random_messages();
		letter_t l, prev;
		int len, phase_start;
		prev = '0;
		for (int phase = 0; phase < 13; phase++) begin
			steady = ($urandom_range(0, 4) == 0);
			load_key_square(random_square());
			phase_start = letters_sent;
			while (letters_sent - phase_start < 100) begin
				len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
				                                   : $urandom_range(9, 40);
				for (int i = 0; i < len; i++) begin
					l = (i > 0 && $urandom_range(0, 9) == 0) ? prev : pick_letter();
					send_letter(l, i == len - 1);
					prev = l;
				end
			end
			wait_idle();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n                 <= 1'b0;
		cfg_wr_en              <= 1'b0;
		cfg_index              <= REG_CELLS_FIRST;
		cfg_data               <= '0;
		letter_bus.valid       <= 1'b0;
		letter_bus.letter      <= '0;
		letter_bus.message_end <= 1'b0;
		key_square    = '0;
		plain_held    = '0;
		plain_holding = 1'b0;
		fail_count    = 0;
		letters_sent  = 0;
		steady        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_blank_square();
		test_directed_pairs();
		test_saturated_square();
		test_random_messages();

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
